>>> sv/lihm_pkg.sv
// Shared types, constants and helpers for the loop idle histogram monitor.
// Used by the statistics block, the bucket cells and the top level.
`default_nettype none

package lihm_pkg;

    localparam int NUM_BUCKETS_DEF   = 23;
    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int MAX_COUNT_WIDTH   = 64;
    localparam int OUT_W             = 32;
    localparam int NS_W              = 44;
    localparam int MS_W              = 24;
    localparam int BOUND_TABLE_SIZE  = 23;

    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    localparam logic [1:0] REQ_TRANSFER = 2'd0;
    localparam logic [1:0] REQ_PUSH     = 2'd1;
    localparam logic [1:0] REQ_END_ITER = 2'd2;
    localparam logic [1:0] REQ_QUERY    = 2'd3;

    // Upper bound in nanoseconds of each log-spaced bucket.
    localparam logic [NS_W-1:0] BOUNDS [BOUND_TABLE_SIZE] = '{
        44'd0,         44'd10000,     44'd17783,     44'd31623,
        44'd56234,     44'd100000,    44'd177828,    44'd316228,
        44'd562341,    44'd1000000,   44'd1778279,   44'd3162278,
        44'd5623413,   44'd10000000,  44'd17782794,  44'd31622777,
        44'd56234133,  44'd100000000, 44'd177827941, 44'd316227766,
        44'd562341325, 44'd1000000000, 44'd10000000000000
    };

    typedef struct packed {
        logic [OUT_W-1:0] iterations;
        logic [OUT_W-1:0] idle_iterations;
        logic [OUT_W-1:0] transfers;
        logic [OUT_W-1:0] pushes;
        logic [OUT_W-1:0] min_work;
        logic [OUT_W-1:0] max_work;
    } totals_t;

    // Payload that travels down the row of bucket cells with each transfer.
    typedef struct packed {
        logic [1:0]       op;
        logic [NS_W-1:0]  ns;
        logic             idle;
        logic             found;
        logic [OUT_W-1:0] sleep_cnt;
        logic [OUT_W-1:0] idle_cnt;
        totals_t          totals;
    } token_t;

    // Buckets past the end of the table repeat the last bound.
    function automatic logic [NS_W-1:0] bound_at(input int idx);
        logic [NS_W-1:0] b;
        if (idx < BOUND_TABLE_SIZE)
        begin
            b = BOUNDS[idx];
        end
        else
        begin
            b = BOUNDS[BOUND_TABLE_SIZE-1];
        end
        return b;
    endfunction

    // Low bits of a counter as reported on the result ports.
    function automatic logic [OUT_W-1:0] to_out(input logic [MAX_COUNT_WIDTH-1:0] v);
        return v[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/loop_idle_histogram_monitor_unit.sv
// Loop idle histogram monitor, top level: entry stage, statistics and a row of bucket cells.
// An input transfer is registered in the entry stage and then in each bucket cell in turn before its result appears.
// Throughput: one item per cycle; the whole cell row moves as one pipeline and
// holds while a finished result waits on out_stall.
// Reset clears both histograms and all totals at once; min_work resets to all ones.
// Depends on lihm_pkg, lihm_stats and lihm_cell.
`default_nettype none

module loop_idle_histogram_monitor_unit #(
    parameter int NUM_BUCKETS = lihm_pkg::NUM_BUCKETS_DEF,
    parameter int COUNT_WIDTH = lihm_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [23:0] sleep_ms,
    input  wire logic [43:0] query_ns,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      sleep_bucket_count,
    output logic [31:0]      idle_bucket_count,
    output logic             bucket_found,
    output logic [31:0]      iterations_total,
    output logic [31:0]      idle_iterations,
    output logic [31:0]      transfers_total,
    output logic [31:0]      pushes_total,
    output logic [31:0]      min_work,
    output logic [31:0]      max_work
);
    import lihm_pkg::*;

    logic            advance;
    logic            accept;
    logic            idle;
    totals_t         totals;
    logic [NS_W-1:0] sleep_ns;
    token_t          entry_tok;
    logic            vld [NUM_BUCKETS+1];
    token_t          tok [NUM_BUCKETS+1];
    logic            entry_vld_reg;
    token_t          entry_tok_reg;

    // The row moves whenever the last cell's result is empty or being taken.
    assign advance  = !vld[NUM_BUCKETS] || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    lihm_stats #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .idle     (idle),
        .totals   (totals)
    );

    assign sleep_ns = NS_W'(sleep_ms) * NS_W'(NS_PER_MS);

    always_comb
    begin
        entry_tok.op        = req_type;
        entry_tok.ns        = (req_type == REQ_END_ITER) ? sleep_ns : query_ns;
        entry_tok.idle      = idle;
        entry_tok.found     = 1'b0;
        entry_tok.sleep_cnt = '0;
        entry_tok.idle_cnt  = '0;
        entry_tok.totals    = totals;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            entry_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            entry_tok_reg <= entry_tok;
        end
    end

    assign vld[0] = entry_vld_reg;
    assign tok[0] = entry_tok_reg;

    for (genvar i = 0; i < NUM_BUCKETS; i++)
    begin : g_cell
        lihm_cell #(
            .IDX         (i),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .vld_in  (vld[i]),
            .tok_in  (tok[i]),
            .vld_out (vld[i+1]),
            .tok_out (tok[i+1])
        );
    end

    assign out_valid          = vld[NUM_BUCKETS];
    assign sleep_bucket_count = tok[NUM_BUCKETS].sleep_cnt;
    assign idle_bucket_count  = tok[NUM_BUCKETS].idle_cnt;
    assign bucket_found       = (tok[NUM_BUCKETS].op == REQ_QUERY) && tok[NUM_BUCKETS].found;
    assign iterations_total   = tok[NUM_BUCKETS].totals.iterations;
    assign idle_iterations    = tok[NUM_BUCKETS].totals.idle_iterations;
    assign transfers_total    = tok[NUM_BUCKETS].totals.transfers;
    assign pushes_total       = tok[NUM_BUCKETS].totals.pushes;
    assign min_work           = tok[NUM_BUCKETS].totals.min_work;
    assign max_work           = tok[NUM_BUCKETS].totals.max_work;

endmodule

`default_nettype wire

>>> sv/lihm_stats.sv
// Loop statistics: event totals, iteration counts and per-iteration work extremes.
// Depends on lihm_pkg.
`default_nettype none

module lihm_stats #(
    parameter int COUNT_WIDTH = lihm_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [1:0]        req_type,
    output logic                   idle,
    output lihm_pkg::totals_t      totals
);
    import lihm_pkg::*;

    logic [COUNT_WIDTH-1:0] work_reg,      work_next;
    logic [COUNT_WIDTH-1:0] iter_reg,      iter_next;
    logic [COUNT_WIDTH-1:0] idle_iter_reg, idle_iter_next;
    logic [COUNT_WIDTH-1:0] transfer_reg,  transfer_next;
    logic [COUNT_WIDTH-1:0] push_reg,      push_next;
    logic [COUNT_WIDTH-1:0] least_reg,     least_next;
    logic [COUNT_WIDTH-1:0] most_reg,      most_next;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    assign idle = (work_reg == '0);

    always_comb
    begin
        work_next      = work_reg;
        iter_next      = iter_reg;
        idle_iter_next = idle_iter_reg;
        transfer_next  = transfer_reg;
        push_next      = push_reg;
        least_next     = least_reg;
        most_next      = most_reg;
        case (req_type)
            REQ_TRANSFER:
            begin
                transfer_next = sat_inc(transfer_reg);
                work_next     = sat_inc(work_reg);
            end
            REQ_PUSH:
            begin
                push_next = sat_inc(push_reg);
                work_next = sat_inc(work_reg);
            end
            REQ_END_ITER:
            begin
                iter_next = sat_inc(iter_reg);
                if (work_reg < least_reg)
                begin
                    least_next = work_reg;
                end
                if (work_reg > most_reg)
                begin
                    most_next = work_reg;
                end
                if (idle)
                begin
                    idle_iter_next = sat_inc(idle_iter_reg);
                end
                work_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // The result reports the totals as they stand after this item.
    always_comb
    begin
        totals.iterations      = to_out(MAX_COUNT_WIDTH'(iter_next));
        totals.idle_iterations = to_out(MAX_COUNT_WIDTH'(idle_iter_next));
        totals.transfers       = to_out(MAX_COUNT_WIDTH'(transfer_next));
        totals.pushes          = to_out(MAX_COUNT_WIDTH'(push_next));
        totals.min_work        = to_out(MAX_COUNT_WIDTH'(least_next));
        totals.max_work        = to_out(MAX_COUNT_WIDTH'(most_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg      <= '0;
            iter_reg      <= '0;
            idle_iter_reg <= '0;
            transfer_reg  <= '0;
            push_reg      <= '0;
            least_reg     <= '1;
            most_reg      <= '0;
        end
        else if (accept)
        begin
            work_reg      <= work_next;
            iter_reg      <= iter_next;
            idle_iter_reg <= idle_iter_next;
            transfer_reg  <= transfer_next;
            push_reg      <= push_next;
            least_reg     <= least_next;
            most_reg      <= most_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/lihm_cell.sv
// One histogram bucket: holds both counts for its bound and passes the
// transfer on to the next cell. Depends on lihm_pkg.
`default_nettype none

module lihm_cell #(
    parameter int IDX         = 0,
    parameter int COUNT_WIDTH = lihm_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              vld_in,
    input  wire lihm_pkg::token_t  tok_in,
    output logic                   vld_out,
    output lihm_pkg::token_t       tok_out
);
    import lihm_pkg::*;

    localparam logic [NS_W-1:0] BOUND = bound_at(IDX);

    logic [COUNT_WIDTH-1:0] sleep_cnt_reg, sleep_cnt_next;
    logic [COUNT_WIDTH-1:0] idle_cnt_reg,  idle_cnt_next;
    logic                   vld_reg;
    token_t                 tok_reg, tok_next;
    logic                   hit;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Bounds never decrease, so the first cell not yet passed that covers
    // the duration is the bucket; later cells see the found flag.
    assign hit = vld_in && !tok_in.found && (tok_in.ns <= BOUND);

    always_comb
    begin
        sleep_cnt_next = sleep_cnt_reg;
        idle_cnt_next  = idle_cnt_reg;
        tok_next       = tok_in;
        if (hit)
        begin
            case (tok_in.op)
                REQ_END_ITER:
                begin
                    tok_next.found = 1'b1;
                    sleep_cnt_next = sat_inc(sleep_cnt_reg);
                    if (tok_in.idle)
                    begin
                        idle_cnt_next = sat_inc(idle_cnt_reg);
                    end
                end
                REQ_QUERY:
                begin
                    tok_next.found     = 1'b1;
                    tok_next.sleep_cnt = to_out(MAX_COUNT_WIDTH'(sleep_cnt_reg));
                    tok_next.idle_cnt  = to_out(MAX_COUNT_WIDTH'(idle_cnt_reg));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_cnt_reg <= '0;
            idle_cnt_reg  <= '0;
            vld_reg       <= 1'b0;
        end
        else if (advance)
        begin
            sleep_cnt_reg <= sleep_cnt_next;
            idle_cnt_reg  <= idle_cnt_next;
            vld_reg       <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign vld_out = vld_reg;
    assign tok_out = tok_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for loop_idle_histogram_monitor_unit: random and directed loop events,
// with a scoreboard that predicts every result transfer field by field.
// Depends on lihm_pkg and the block's RTL.

module tb;
    import lihm_pkg::*;

    localparam int NB           = NUM_BUCKETS_DEF;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [31:0] sleep_cnt;
        logic [31:0] idle_cnt;
        logic        found;
        logic [31:0] iterations;
        logic [31:0] idle_iters;
        logic [31:0] transfers;
        logic [31:0] pushes;
        logic [31:0] least_work;
        logic [31:0] most_work;
    } report_t;

    class loop_stats_scoreboard;
        logic [31:0] sleep_hist [NB];
        logic [31:0] idle_hist [NB];
        logic [31:0] work_in_iter;
        logic [31:0] iter_cnt;
        logic [31:0] idle_iter_cnt;
        logic [31:0] xfer_cnt;
        logic [31:0] push_cnt;
        logic [31:0] fewest_work;
        logic [31:0] most_work;
        report_t     expected_reports [$];
        int          errors;

        function new();
            foreach (sleep_hist[i])
            begin
                sleep_hist[i] = '0;
                idle_hist[i]  = '0;
            end
            work_in_iter  = '0;
            iter_cnt      = '0;
            idle_iter_cnt = '0;
            xfer_cnt      = '0;
            push_cnt      = '0;
            fewest_work   = '1;
            most_work     = '0;
            errors        = 0;
        endfunction

        // Counters stick at all ones.
        function logic [31:0] bump(logic [31:0] v);
            return (v == '1) ? v : v + 32'd1;
        endfunction

        // First bucket whose bound is not exceeded, or NB when past every bound.
        function int bucket_of(logic [63:0] ns);
            for (int i = 0; i < NB; i++)
            begin
                if (ns <= 64'(BOUNDS[i]))
                begin
                    return i;
                end
            end
            return NB;
        endfunction

        function void note_request(logic [1:0] kind, logic [23:0] ms, logic [43:0] ns);
            report_t r;
            int      b;
            logic    no_work;
            r = '{default: '0};
            case (kind)
                REQ_TRANSFER:
                begin
                    xfer_cnt     = bump(xfer_cnt);
                    work_in_iter = bump(work_in_iter);
                end
                REQ_PUSH:
                begin
                    push_cnt     = bump(push_cnt);
                    work_in_iter = bump(work_in_iter);
                end
                REQ_END_ITER:
                begin
                    no_work = (work_in_iter == '0);
                    b = bucket_of(64'(ms) * 64'(NS_PER_MS));
                    if (b < NB)
                    begin
                        sleep_hist[b] = bump(sleep_hist[b]);
                        if (no_work)
                        begin
                            idle_hist[b] = bump(idle_hist[b]);
                        end
                    end
                    iter_cnt = bump(iter_cnt);
                    if (work_in_iter < fewest_work)
                    begin
                        fewest_work = work_in_iter;
                    end
                    if (work_in_iter > most_work)
                    begin
                        most_work = work_in_iter;
                    end
                    if (no_work)
                    begin
                        idle_iter_cnt = bump(idle_iter_cnt);
                    end
                    work_in_iter = '0;
                end
                default:
                begin
                    b = bucket_of(64'(ns));
                    if (b < NB)
                    begin
                        r.sleep_cnt = sleep_hist[b];
                        r.idle_cnt  = idle_hist[b];
                        r.found     = 1'b1;
                    end
                end
            endcase
            r.iterations = iter_cnt;
            r.idle_iters = idle_iter_cnt;
            r.transfers  = xfer_cnt;
            r.pushes     = push_cnt;
            r.least_work = fewest_work;
            r.most_work  = most_work;
            expected_reports.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (expected_reports.size() == 0)
            begin
                $error("result transfer with no outstanding request");
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            compare("sleep_bucket_count", want.sleep_cnt, got.sleep_cnt);
            compare("idle_bucket_count", want.idle_cnt, got.idle_cnt);
            compare("bucket_found", 32'(want.found), 32'(got.found));
            compare("iterations_total", want.iterations, got.iterations);
            compare("idle_iterations", want.idle_iters, got.idle_iters);
            compare("transfers_total", want.transfers, got.transfers);
            compare("pushes_total", want.pushes, got.pushes);
            compare("min_work", want.least_work, got.least_work);
            compare("max_work", want.most_work, got.most_work);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_TRANSFER;
    logic [23:0] sleep_ms = '0;
    logic [43:0] query_ns = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] sleep_bucket_count;
    logic [31:0] idle_bucket_count;
    logic        bucket_found;
    logic [31:0] iterations_total;
    logic [31:0] idle_iterations;
    logic [31:0] transfers_total;
    logic [31:0] pushes_total;
    logic [31:0] min_work;
    logic [31:0] max_work;

    int send_gap_pct = 26;
    int recv_stall_pct = 47;
    int items_sent = 0;
    int cycle_count = 0;

    loop_stats_scoreboard sb;

    loop_idle_histogram_monitor_unit uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .req_type           (req_type),
        .sleep_ms           (sleep_ms),
        .query_ns           (query_ns),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .sleep_bucket_count (sleep_bucket_count),
        .idle_bucket_count  (idle_bucket_count),
        .bucket_found       (bucket_found),
        .iterations_total   (iterations_total),
        .idle_iterations    (idle_iterations),
        .transfers_total    (transfers_total),
        .pushes_total       (pushes_total),
        .min_work           (min_work),
        .max_work           (max_work)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        report_t seen;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                seen.sleep_cnt  = sleep_bucket_count;
                seen.idle_cnt   = idle_bucket_count;
                seen.found      = bucket_found;
                seen.iterations = iterations_total;
                seen.idle_iters = idle_iterations;
                seen.transfers  = transfers_total;
                seen.pushes     = pushes_total;
                seen.least_work = min_work;
                seen.most_work  = max_work;
                sb.check_report(seen);
            end
            if (in_valid && in_stall === 1'b0)
            begin
                sb.note_request(req_type, sleep_ms, query_ns);
            end
        end
    end

    // Valid stays high from one transfer into the next unless a gap is drawn.
    task automatic send_item(input logic [1:0] kind, input logic [23:0] ms,
                             input logic [43:0] ns);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        sleep_ms <= ms;
        query_ns <= ns;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    initial
    begin
        int          first_random;
        int          pick;
        int          idx;
        logic [23:0] ms;
        logic [43:0] ns;
        logic [63:0] wide;

        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty histograms, bucket edges, and sleeps and queries past the last bound.
        send_item(REQ_QUERY, 24'd5, 44'd0);
        send_item(REQ_END_ITER, 24'd0, 44'd0);
        send_item(REQ_QUERY, 24'd0, 44'd0);
        send_item(REQ_TRANSFER, 24'hFFFFFF, 44'hFFFFFFFFFFF);
        send_item(REQ_PUSH, 24'd0, 44'd0);
        send_item(REQ_PUSH, 24'd7, 44'd9);
        send_item(REQ_END_ITER, 24'd1, 44'd0);
        send_item(REQ_QUERY, 24'd0, 44'd1000000);
        send_item(REQ_QUERY, 24'd0, 44'd999999);
        send_item(REQ_END_ITER, 24'hFFFFFF, 44'd0);
        send_item(REQ_END_ITER, 24'd10000000, 44'd0);
        send_item(REQ_END_ITER, 24'd10000001, 44'd0);
        send_item(REQ_QUERY, 24'd0, BOUNDS[NB-1]);
        send_item(REQ_QUERY, 24'd0, BOUNDS[NB-1] + 44'd1);
        send_item(REQ_QUERY, 24'd0, 44'hFFFFFFFFFFF);
        send_item(REQ_QUERY, 24'd0, 44'd1);
        send_item(REQ_TRANSFER, 24'd0, 44'd0);
        send_item(REQ_END_ITER, 24'd1000, 44'd0);
        send_item(REQ_QUERY, 24'd0, 44'd1000000000);
        send_item(REQ_END_ITER, 24'd1001, 44'd0);
        send_item(REQ_QUERY, 24'hFFFFFF, 44'd1000000001);

        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS)
        begin
            if (items_sent - first_random >= 2 * RANDOM_ITEMS / 3)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            else if (items_sent - first_random >= RANDOM_ITEMS / 3)
            begin
                send_gap_pct   = 47;
                recv_stall_pct = 26;
            end

            // Sleep times mostly land in the populated buckets, sometimes on an edge or far out.
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                ms = '0;
            end
            else if (pick < 50)
            begin
                ms = 24'($urandom_range(1000, 1));
            end
            else if (pick < 65)
            begin
                case ($urandom_range(3))
                    0: ms = 24'd1;
                    1: ms = 24'd1000;
                    2: ms = 24'd10000000;
                    default: ms = 24'd10000001;
                endcase
            end
            else if (pick < 80)
            begin
                ms = 24'($urandom_range(10000000, 1001));
            end
            else
            begin
                ms = 24'($urandom);
            end

            pick = $urandom_range(99);
            if (pick < 50)
            begin
                idx = $urandom_range(NB - 1);
                ns = BOUNDS[idx];
                case ($urandom_range(2))
                    0: if (ns != '0) ns = ns - 44'd1;
                    1: ns = ns + 44'd1;
                    default: ;
                endcase
            end
            else if (pick < 75)
            begin
                ns = 44'($urandom_range(1000000000));
            end
            else
            begin
                wide = {$urandom, $urandom};
                ns = wide[43:0];
            end

            pick = $urandom_range(99);
            if (pick < 4)
            begin
                repeat ($urandom_range(40, 8))
                begin
                    send_item($urandom_range(1) ? REQ_PUSH : REQ_TRANSFER, ms, ns);
                end
                send_item(REQ_END_ITER, ms, ns);
            end
            else if (pick < 8)
            begin
                repeat ($urandom_range(4, 2))
                begin
                    send_item(REQ_END_ITER, ms, ns);
                end
            end
            else if (pick < 38)
            begin
                send_item(REQ_TRANSFER, ms, ns);
            end
            else if (pick < 60)
            begin
                send_item(REQ_PUSH, ms, ns);
            end
            else if (pick < 80)
            begin
                send_item(REQ_END_ITER, ms, ns);
            end
            else
            begin
                send_item(REQ_QUERY, ms, ns);
            end
        end
        in_valid <= 1'b0;

        while (sb.expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        // Let any stray result transfer show up before the verdict.
        repeat (NB + 8) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
sv/lihm_pkg.sv
sv/lihm_stats.sv
sv/lihm_cell.sv
sv/loop_idle_histogram_monitor_unit.sv
tb/tb.sv
